// ===== sv/hdtlb_pkg.sv =====
`default_nettype none

package hdtlb_pkg;

    // field widths
    localparam int CMD_W    = 2;
    localparam int PID_W    = 8;
    localparam int PAGE_W   = 14;
    localparam int FRAME_W  = 13;
    localparam int STATUS_W = 2;
    localparam int LIMIT_W  = 15;

    // hash: pid*9173 + page + 971 never exceeds 22 bits, so the 22-bit sum never wraps
    localparam int HASH_W = 22;
    localparam logic [HASH_W-1:0] HASH_MUL = HASH_W'(9173);
    localparam logic [HASH_W-1:0] HASH_ADD = HASH_W'(971);

    localparam int unsigned TLB_ENTRIES_DEF = 256;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16384);

    // commands
    localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INVAL  = 2'd2;

    // response status
    localparam logic [STATUS_W-1:0] STATUS_HIT     = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BADPAGE = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_DONE    = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [PID_W-1:0]   process_id;
        logic [PAGE_W-1:0]  page_number;
        logic [FRAME_W-1:0] frame_in;
    } tlb_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FRAME_W-1:0]  frame_out;
    } tlb_rsp_t;

    typedef struct packed {
        logic               valid;
        logic [PID_W-1:0]   pid;
        logic [PAGE_W-1:0]  page;
        logic [FRAME_W-1:0] frame;
    } tlb_slot_t;

endpackage

`default_nettype wire

// ===== sv/hashed_direct_mapped_tlb_unit.sv =====
// flow: a request passes the slot index unit, the registered slot read and the compare stage
//   into the output register; when TLB_ENTRIES is not a power of two the index unit adds the
//   two reciprocal multiply steps of the slot remainder
// one request in flight; the output register frees the input side for the next request
// reset: after rst_n rises, a clearing pass writes every slot invalid with in_ready low;
//   page_limit resets to 16384, configuration writes are taken at once
`default_nettype none

module hashed_direct_mapped_tlb_unit #(
    parameter int unsigned TLB_ENTRIES = hdtlb_pkg::TLB_ENTRIES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // request channel
    input  wire logic                            in_valid,
    output logic                                 in_ready,
    input  wire hdtlb_pkg::tlb_req_t             in_item,
    // response channel
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output hdtlb_pkg::tlb_rsp_t                  out_item,
    // page_limit write channel
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [hdtlb_pkg::LIMIT_W-1:0]   cfg_data
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    // sequencer states
    localparam logic [1:0] S_CLEAR = 2'd0;  // post-reset sweep of the slot store
    localparam logic [1:0] S_IDLE  = 2'd1;  // waiting for a request
    localparam logic [1:0] S_HASH  = 2'd2;  // slot index being computed
    localparam logic [1:0] S_CMP   = 2'd3;  // slot read data back, compare and write back

    logic [1:0]                       state_reg, state_next;
    logic [IDX_W-1:0]                 clr_reg, clr_next;
    logic [hdtlb_pkg::LIMIT_W-1:0]    limit_reg;

    // captured request
    hdtlb_pkg::tlb_req_t              req_reg;
    logic                             bad_reg;

    // output register
    logic                             out_valid_reg, out_valid_next;
    hdtlb_pkg::tlb_rsp_t              out_item_reg;
    hdtlb_pkg::tlb_rsp_t              rsp_next;
    logic                             rsp_load;

    // slot store
    hdtlb_pkg::tlb_slot_t             slot_mem [TLB_ENTRIES];
    hdtlb_pkg::tlb_slot_t             rd_entry_reg;
    hdtlb_pkg::tlb_slot_t             wr_entry;
    hdtlb_pkg::tlb_slot_t             wr_data;
    logic [IDX_W-1:0]                 wr_addr;
    logic                             mem_we;
    logic                             mem_re;
    logic                             cmp_we;

    // slot index unit
    logic                             in_xfer;
    logic                             hash_done;
    logic [IDX_W-1:0]                 hash_slot;
    logic [IDX_W-1:0]                 slot_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // hash is taken straight from the request on the transfer edge
    hdtlb_slot_hash #(
        .TLB_ENTRIES (TLB_ENTRIES)
    ) u_slot_hash (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_xfer),
        .process_id  (in_item.process_id),
        .page_number (in_item.page_number),
        .done        (hash_done),
        .slot        (hash_slot)
    );

    // result and write-back for the request held in req_reg
    always_comb
    begin
        rsp_next.status    = hdtlb_pkg::STATUS_MISS;
        rsp_next.frame_out = '0;
        cmp_we             = 1'b0;
        wr_entry           = '0;
        if (bad_reg)
        begin
            rsp_next.status = hdtlb_pkg::STATUS_BADPAGE;
        end
        else
        begin
            unique case (req_reg.cmd)
                hdtlb_pkg::CMD_LOOKUP:
                begin
                    if (rd_entry_reg.valid && rd_entry_reg.pid == req_reg.process_id
                        && rd_entry_reg.page == req_reg.page_number)
                    begin
                        rsp_next.status    = hdtlb_pkg::STATUS_HIT;
                        rsp_next.frame_out = rd_entry_reg.frame;
                    end
                end
                hdtlb_pkg::CMD_FILL:
                begin
                    cmp_we          = 1'b1;
                    wr_entry.valid  = 1'b1;
                    wr_entry.pid    = req_reg.process_id;
                    wr_entry.page   = req_reg.page_number;
                    wr_entry.frame  = req_reg.frame_in;
                    rsp_next.status = hdtlb_pkg::STATUS_DONE;
                end
                hdtlb_pkg::CMD_INVAL:
                begin
                    // slot cleared whatever tag it holds
                    cmp_we          = 1'b1;
                    rsp_next.status = hdtlb_pkg::STATUS_DONE;
                end
                default:
                begin
                    // unused command code answers as a miss
                    rsp_next.status = hdtlb_pkg::STATUS_MISS;
                end
            endcase
        end
    end

    // response goes out only when the output register is free or being drained
    assign rsp_load = (state_reg == S_CMP) && (!out_valid_reg || out_ready);

    // clear sweep and compare stage share the single write port; never in the same cycle
    assign mem_we  = (state_reg == S_CLEAR) || (rsp_load && cmp_we);
    assign wr_addr = (state_reg == S_CLEAR) ? clr_reg : slot_reg;
    // sweep writes empty slots regardless of any stale request
    assign wr_data = (state_reg == S_CLEAR) ? hdtlb_pkg::tlb_slot_t'('0) : wr_entry;
    assign mem_re  = (state_reg == S_HASH) && hash_done;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            out_valid_next = 1'b1;
        end
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_next = IDX_W'(clr_reg + 1'b1);
                if (clr_reg == LAST_IDX)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    state_next = S_HASH;
                end
            end
            S_HASH:
            begin
                if (hash_done)
                begin
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                if (rsp_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            limit_reg     <= hdtlb_pkg::LIMIT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            req_reg <= in_item;
            // bad page rejects every command and leaves the store alone
            bad_reg <= ({1'b0, in_item.page_number} >= limit_reg);
        end
        if (hash_done)
        begin
            slot_reg <= hash_slot;
        end
        if (rsp_load)
        begin
            out_item_reg <= rsp_next;
        end
    end

    // slot store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            slot_mem[wr_addr] <= wr_data;
        end
        if (mem_re)
        begin
            rd_entry_reg <= slot_mem[hash_slot];
        end
    end

    // only one request in flight: input closes right after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while another is in flight");

    // store is written only by the clear sweep or the compare stage
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg == S_CLEAR || state_reg == S_CMP))
        else $error("slot store written outside sweep or compare");

    // index unit answers only for the request being hashed
    assert property (@(posedge clk) disable iff (!rst_n)
        hash_done |-> state_reg == S_HASH)
        else $error("slot index ready outside hash state");

    // only a hit carries a frame
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.status != hdtlb_pkg::STATUS_HIT |-> out_item.frame_out == '0)
        else $error("frame driven on a non-hit response");

    // a bad page never changes the store
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP && bad_reg |-> !mem_we)
        else $error("store written for an out-of-range page");

endmodule

`default_nettype wire

// ===== sv/hdtlb_slot_hash.sv =====
`default_nettype none

module hdtlb_slot_hash #(
    parameter int unsigned TLB_ENTRIES = hdtlb_pkg::TLB_ENTRIES_DEF,
    localparam int IDX_W = $clog2(TLB_ENTRIES)
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [hdtlb_pkg::PID_W-1:0]    process_id,
    input  wire logic [hdtlb_pkg::PAGE_W-1:0]   page_number,
    output logic                                done,
    output logic [IDX_W-1:0]                    slot
);

    localparam int HASH_W = hdtlb_pkg::HASH_W;

    logic [HASH_W-1:0] h_comb;
    logic              done_reg;
    logic [IDX_W-1:0]  slot_reg;

    // 8x14 multiply plus add, combinational
    assign h_comb = HASH_W'(process_id) * hdtlb_pkg::HASH_MUL
                  + HASH_W'(page_number) + hdtlb_pkg::HASH_ADD;

    generate
        if ((TLB_ENTRIES & (TLB_ENTRIES - 1)) == 0) begin : g_pow2
            // remainder is a mask
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    done_reg <= 1'b0;
                end
                else
                begin
                    done_reg <= start;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    slot_reg <= h_comb[IDX_W-1:0];
                end
            end
        end
        else begin : g_recip
            // remainder by reciprocal multiply: quotient first, then hash minus quotient*entries
            localparam int SHIFT  = HASH_W + IDX_W;
            localparam int PROD_W = 2 * HASH_W + 1;
            localparam logic [HASH_W:0] RECIP =
                (HASH_W + 1)'(((64'd1 << SHIFT) + 64'(TLB_ENTRIES) - 64'd1)
                              / 64'(TLB_ENTRIES));
            localparam logic [HASH_W-1:0] DIVISOR = HASH_W'(TLB_ENTRIES);

            logic [HASH_W-1:0] h_reg;
            logic [HASH_W-1:0] quot_reg;
            logic [PROD_W-1:0] prod;
            logic [IDX_W-1:0]  rem;
            logic              h_valid_reg;
            logic              quot_valid_reg;

            // 22x23 product, exact quotient for every 22-bit hash
            assign prod = PROD_W'(h_reg) * PROD_W'(RECIP);
            assign rem  = IDX_W'(h_reg - quot_reg * DIVISOR);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    h_valid_reg    <= 1'b0;
                    quot_valid_reg <= 1'b0;
                    done_reg       <= 1'b0;
                end
                else
                begin
                    h_valid_reg    <= start;
                    quot_valid_reg <= h_valid_reg;
                    done_reg       <= quot_valid_reg;
                end
            end

            always_ff @(posedge clk)
            begin
                if (start)
                begin
                    h_reg <= h_comb;
                end
                if (h_valid_reg)
                begin
                    quot_reg <= HASH_W'(prod >> SHIFT);
                end
                if (quot_valid_reg)
                begin
                    slot_reg <= rem;
                end
            end
        end
    endgenerate

    assign done = done_reg;
    assign slot = slot_reg;

endmodule

`default_nettype wire
